@@ rtl/pts_pkg.sv @@
// Package for the periodic task slot scheduler.
// Holds op and status codes, the slot record, result and flag types.
// No dependencies.
`default_nettype none

package pts_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ADD      = 3'd1,
    OP_RESTART  = 3'd2,
    OP_STOP     = 3'd3,
    OP_DISPATCH = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_FIRED = 3'd1,
    ST_NONE  = 3'd2,
    ST_FULL  = 3'd3,
    ST_NOID  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_EMIT
  } state_t;

  localparam int MAX_RESULTS = 20;
  localparam int RES_W       = 5;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [16:0] count;
    logic [15:0] period;
    logic [7:0]  repeats;
  } slot_rec_t;

  localparam slot_rec_t SLOT_RESET = '{task_id: 8'd0, count: 17'd1,
                                       period: 16'd0, repeats: 8'd0};

  typedef struct packed {
    logic wr;
    logic hit;
    logic fire;
  } alu_flags_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  slot_index;
    logic [7:0]  fired_task;
  } result_t;

  function automatic result_t mk_res(status_t st, logic [4:0] idx, logic [7:0] tsk);
    result_t r;
    r.status     = st;
    r.slot_index = idx;
    r.fired_task = tsk;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pts_if.sv @@
// Channel interfaces of the periodic task slot scheduler.
// Input item channel and result channel, valid/ready; no dependencies.
`default_nettype none

interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  task_id;
  logic [15:0] period_ticks;
  logic [7:0]  repeat_limit;

  modport source (output valid, op, task_id, period_ticks, repeat_limit, input ready);
  modport sink   (input valid, op, task_id, period_ticks, repeat_limit, output ready);
endinterface

interface pts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] slot_index;
  logic [7:0] fired_task;
  logic       last;

  modport source (output valid, status, slot_index, fired_task, last, input ready);
  modport sink   (input valid, status, slot_index, fired_task, last, output ready);
endinterface

`default_nettype wire

@@ rtl/pts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/pts_slot_alu.sv @@
// Shared slot update unit: one counter compare, one increment, one id match.
// Depends on pts_pkg.
`default_nettype none

module pts_slot_alu (
  input  pts_pkg::op_t       op,
  input  logic [7:0]         task_id,
  input  logic [15:0]        period_ticks,
  input  logic [7:0]         repeat_limit,
  input  pts_pkg::slot_rec_t rec_in,
  output pts_pkg::slot_rec_t rec_out,
  output pts_pkg::alu_flags_t flags
);

  logic due;

  always_comb begin
    due     = (rec_in.period != 16'd0) && (rec_in.count > {1'b0, rec_in.period});
    rec_out = rec_in;
    flags   = '0;
    unique case (op)
      pts_pkg::OP_TICK: begin
        // advance up to period+1
        if ((rec_in.period != 16'd0) && !due) begin
          rec_out.count = rec_in.count + 17'd1;
          flags.wr      = 1'b1;
        end
      end
      pts_pkg::OP_ADD: begin
        flags.hit       = (rec_in.task_id == 8'd0);
        flags.wr        = flags.hit;
        rec_out.task_id = task_id;
        rec_out.period  = period_ticks;
        rec_out.repeats = repeat_limit;
      end
      pts_pkg::OP_RESTART: begin
        flags.hit       = (rec_in.task_id == task_id) || (rec_in.task_id == 8'd0);
        flags.wr        = flags.hit;
        rec_out.task_id = task_id;
        rec_out.period  = period_ticks;
        rec_out.repeats = repeat_limit;
      end
      pts_pkg::OP_STOP: begin
        flags.hit       = (rec_in.task_id == task_id);
        flags.wr        = flags.hit;
        rec_out.period  = 16'd0;
        rec_out.repeats = 8'd0;
      end
      pts_pkg::OP_DISPATCH: begin
        flags.fire    = due;
        flags.wr      = due;
        rec_out.count = 17'd1;
        if (rec_in.repeats != 8'd0) begin
          rec_out.repeats = rec_in.repeats - 8'd1;
          if (rec_in.repeats == 8'd1) begin
            rec_out.period = 16'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/periodic_task_slot_scheduler.sv @@
// Periodic task slot scheduler, top level.
// Depends on pts_pkg, pts_if, pts_ram and pts_slot_alu.
//
// A table of SLOTS task slots lives in one RAM; a small sequencer walks it
// one slot at a time through a shared update unit. Every slot visit is a
// RAM read (S_READ), then evaluate and write back (S_EVAL); tick, dispatch
// and an unsuccessful add/restart/stop visit every slot before the final
// result, and a stall on the result side can hold an item at work. Add,
// restart and stop end at the first matching slot. Add, restart and stop
// items with a zero task id, and items with an unused op code, answer
// without touching the table. The input is not ready while an item
// is at work. Dispatch reports each fired slot as its own result transfer,
// in index order, and marks the final one with last; beyond the first
// MAX_RESULTS firings slots still fire but are not reported. A slot the
// sequencer has never written reads as empty (per-slot valid flops cleared
// by reset), so no clearing pass runs after reset. A finished result waits
// in an output register while the block takes the next item.
`default_nettype none

module periodic_task_slot_scheduler #(
  parameter int SLOTS = 20
) (
  input  logic clk,
  input  logic rst_n,
  pts_in_if.sink    in_item,
  pts_out_if.source out_res
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [pts_pkg::RES_W-1:0] RES_CAP = pts_pkg::RES_W'(pts_pkg::MAX_RESULTS);

  pts_pkg::state_t  state_r, state_nxt;
  pts_pkg::op_t     op_r;
  logic [7:0]       id_r;
  logic [15:0]      per_r;
  logic [7:0]       rep_r;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [pts_pkg::RES_W-1:0] nres_r, nres_nxt;
  pts_pkg::result_t pend_r, pend_nxt;
  logic [SLOTS-1:0] valid_r;

  logic             out_valid_r;
  pts_pkg::result_t out_r;
  logic             out_last_r;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             out_load_last;
  logic             ram_we;
  logic [$bits(pts_pkg::slot_rec_t)-1:0] ram_rdata;
  pts_pkg::slot_rec_t rec_cur, rec_new;
  pts_pkg::alu_flags_t flags;
  logic [IW+4:0]    idx_wide;
  logic [4:0]       idx_o;
  logic             find_op;

  assign in_acc   = in_item.valid && in_item.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign idx_wide = {5'b0, idx_r};
  assign idx_o    = idx_wide[4:0];
  assign find_op  = (op_r == pts_pkg::OP_ADD) || (op_r == pts_pkg::OP_RESTART) ||
                    (op_r == pts_pkg::OP_STOP);

  // never-written slots read as the reset record
  assign rec_cur = valid_r[idx_r] ? pts_pkg::slot_rec_t'(ram_rdata) : pts_pkg::SLOT_RESET;

  pts_ram #(
    .WIDTH ($bits(pts_pkg::slot_rec_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (rec_new),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  pts_slot_alu u_alu (
    .op           (op_r),
    .task_id      (id_r),
    .period_ticks (per_r),
    .repeat_limit (rep_r),
    .rec_in       (rec_cur),
    .rec_out      (rec_new),
    .flags        (flags)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pts_pkg::S_IDLE;
      valid_r <= '0;
      nres_r  <= '0;
    end else begin
      state_r <= state_nxt;
      nres_r  <= nres_nxt;
      if (ram_we) begin
        valid_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
    if (in_acc) begin
      op_r  <= pts_pkg::op_t'(in_item.op);
      id_r  <= in_item.task_id;
      per_r <= in_item.period_ticks;
      rep_r <= in_item.repeat_limit;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    nres_nxt      = nres_r;
    pend_nxt      = pend_r;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    unique case (state_r)
      pts_pkg::S_IDLE: begin
        if (in_acc) begin
          idx_nxt  = '0;
          nres_nxt = '0;
          case (in_item.op) inside
            pts_pkg::OP_TICK, pts_pkg::OP_DISPATCH: begin
              state_nxt = pts_pkg::S_READ;
            end
            pts_pkg::OP_ADD, pts_pkg::OP_RESTART, pts_pkg::OP_STOP: begin
              if (in_item.task_id == 8'd0) begin
                pend_nxt  = pts_pkg::mk_res(pts_pkg::ST_NOID, 5'd0, 8'd0);
                state_nxt = pts_pkg::S_EMIT;
              end else begin
                state_nxt = pts_pkg::S_READ;
              end
            end
            default: begin
              // unused op codes: no table access
              pend_nxt  = pts_pkg::mk_res(pts_pkg::ST_DONE, 5'd0, 8'd0);
              state_nxt = pts_pkg::S_EMIT;
            end
          endcase
        end
      end
      pts_pkg::S_READ: begin
        state_nxt = pts_pkg::S_EVAL;
      end
      pts_pkg::S_EVAL: begin
        // hold when a reported firing must push out the previous one
        if (flags.fire && (nres_r != '0) && (nres_r < RES_CAP) && !out_free) begin
          state_nxt = pts_pkg::S_EVAL;
        end else begin
          ram_we = flags.wr;
          if (flags.fire && (nres_r < RES_CAP)) begin
            if (nres_r != '0) begin
              out_load = 1'b1;
            end
            pend_nxt = pts_pkg::mk_res(pts_pkg::ST_FIRED, idx_o, rec_cur.task_id);
            nres_nxt = nres_r + 1'b1;
          end
          if (find_op && flags.hit) begin
            pend_nxt  = pts_pkg::mk_res(pts_pkg::ST_DONE, idx_o, id_r);
            state_nxt = pts_pkg::S_EMIT;
          end else if (idx_r == LAST_IDX) begin
            state_nxt = pts_pkg::S_EMIT;
            case (op_r) inside
              pts_pkg::OP_ADD, pts_pkg::OP_RESTART: begin
                pend_nxt = pts_pkg::mk_res(pts_pkg::ST_FULL, 5'd0, id_r);
              end
              pts_pkg::OP_STOP: begin
                pend_nxt = pts_pkg::mk_res(pts_pkg::ST_NOID, 5'd0, id_r);
              end
              pts_pkg::OP_DISPATCH: begin
                if (nres_nxt == '0) begin
                  pend_nxt = pts_pkg::mk_res(pts_pkg::ST_NONE, 5'd0, 8'd0);
                end
              end
              default: begin
                pend_nxt = pts_pkg::mk_res(pts_pkg::ST_DONE, 5'd0, 8'd0);
              end
            endcase
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = pts_pkg::S_READ;
          end
        end
      end
      pts_pkg::S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          state_nxt     = pts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pts_pkg::S_IDLE;
      end
    endcase
  end

  // Output register: the pending result moves here on each transfer slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r      <= pend_r;
      out_last_r <= out_load_last;
    end
  end

  assign in_item.ready      = (state_r == pts_pkg::S_IDLE);
  assign out_res.valid      = out_valid_r;
  assign out_res.status     = out_r.status;
  assign out_res.slot_index = out_r.slot_index;
  assign out_res.fired_task = out_r.fired_task;
  assign out_res.last       = out_last_r;

endmodule

`default_nettype wire

@@ rtl/pts_checker.sv @@
// Port-level checks for the periodic task slot scheduler, bound to the top.
// Depends on pts_pkg and periodic_task_slot_scheduler.
`default_nettype none

module pts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [4:0] out_slot_index,
  input logic [7:0] out_fired_task,
  input logic       out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_slot_index) && $stable(out_fired_task) && $stable(out_last))
    else $error("result changed while stalled");

  // busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // only firings come in runs; every other answer closes its item
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pts_pkg::ST_FIRED) |-> out_last)
    else $error("non-fired result without last");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pts_pkg::ST_NONE) |->
      (out_slot_index == 5'd0) && (out_fired_task == 8'd0))
    else $error("nothing-fired result carries a slot");

endmodule

bind periodic_task_slot_scheduler pts_checker u_pts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_item.valid),
  .in_ready       (in_item.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_status     (out_res.status),
  .out_slot_index (out_res.slot_index),
  .out_fired_task (out_res.fired_task),
  .out_last       (out_res.last)
);

`default_nettype wire
